>>> rtl/fixed_point_alu_q24_8_unit_defines.svh
// Assertion macros used by the checker file
`ifndef FIXED_POINT_ALU_Q24_8_UNIT_DEFINES_SVH
`define FIXED_POINT_ALU_Q24_8_UNIT_DEFINES_SVH

// Property over a clock and an active low reset
`define FXA_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same property, checked during reset too
`define FXA_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/fxalu_pkg.sv
// Types and operation codes for the fixed-point ALU
package fxalu_pkg;

  localparam logic [3:0] FN_ADD     = 4'd0;
  localparam logic [3:0] FN_SUB     = 4'd1;
  localparam logic [3:0] FN_MUL     = 4'd2;
  localparam logic [3:0] FN_DIV     = 4'd3;
  localparam logic [3:0] FN_GT      = 4'd4;
  localparam logic [3:0] FN_LT      = 4'd5;
  localparam logic [3:0] FN_GE      = 4'd6;
  localparam logic [3:0] FN_LE      = 4'd7;
  localparam logic [3:0] FN_EQ      = 4'd8;
  localparam logic [3:0] FN_NE      = 4'd9;
  localparam logic [3:0] FN_MIN     = 4'd10;
  localparam logic [3:0] FN_MAX     = 4'd11;
  localparam logic [3:0] FN_INC     = 4'd12;
  localparam logic [3:0] FN_DEC     = 4'd13;
  localparam logic [3:0] FN_TO_INT  = 4'd14;
  localparam logic [3:0] FN_FROM_INT = 4'd15;

  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  // Result of the simple (non mul/div) path, carried along the pipeline
  typedef struct packed {
    logic [3:0]        func;
    logic signed [31:0] simple_res;
    logic              cmp;
  } fxa_side_t;

  function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) r = S32_MAX;
    else if (v < -64'sh0000_0000_8000_0000) r = S32_MIN;
    else r = v[31:0];
    return r;
  endfunction

endpackage

>>> rtl/fixed_point_alu_q24_8_unit.sv
// Q24.8 fixed-point ALU: pipelined over 35+FRAC_BITS register stages.
// Throughput: one transaction per cycle while the output is not stalled;
// the division pipeline, one quotient bit per stage, sets the depth.
// Reset clears all stage valid bits; data registers are not reset.
module fixed_point_alu_q24_8_unit
  import fxalu_pkg::*;
#(
  parameter int FRAC_BITS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [3:0]         func_i,
  input  logic signed [31:0] operand_a_i,
  input  logic signed [31:0] operand_b_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] result_raw_o,
  output logic               compare_true_o,
  output logic               divide_by_zero_o
);
  fxa_side_t          side;
  logic signed [31:0] simple_res;
  logic               simple_cmp;
  logic               adv;

  fxalu_simple #(.FRAC_BITS(FRAC_BITS)) u_simple (
    .func_i (func_i),
    .a_i    (operand_a_i),
    .b_i    (operand_b_i),
    .res_o  (simple_res),
    .cmp_o  (simple_cmp)
  );
  assign side = '{func: func_i, simple_res: simple_res, cmp: simple_cmp};

  // Whole pipeline moves together; hold while the output is stalled
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  fxalu_pipe #(.FRAC_BITS(FRAC_BITS)) u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .in_valid_i  (in_valid_i),
    .in_side_i   (side),
    .a_i         (operand_a_i),
    .b_i         (operand_b_i),
    .out_valid_o (out_valid_o),
    .res_o       (result_raw_o),
    .cmp_o       (compare_true_o),
    .dz_o        (divide_by_zero_o)
  );
endmodule

>>> rtl/fxalu_simple.sv
// Combinational operations: add/sub, compares, min/max, inc/dec, conversions
module fxalu_simple
  import fxalu_pkg::*;
#(
  parameter int FRAC_BITS = 8
) (
  input  logic [3:0]         func_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  output logic signed [31:0] res_o,
  output logic               cmp_o
);
  logic signed [63:0] a64, b64, sh;

  always_comb begin
    a64 = 64'(a_i);
    b64 = 64'(b_i);
    sh  = a64 <<< FRAC_BITS;
    res_o = '0;
    cmp_o = 1'b0;
    case (func_i)
      FN_ADD:      res_o = sat64(a64 + b64);
      FN_SUB:      res_o = sat64(a64 - b64);
      FN_GT:       cmp_o = a_i > b_i;
      FN_LT:       cmp_o = a_i < b_i;
      FN_GE:       cmp_o = a_i >= b_i;
      FN_LE:       cmp_o = a_i <= b_i;
      FN_EQ:       cmp_o = a_i == b_i;
      FN_NE:       cmp_o = a_i != b_i;
      FN_MIN:      res_o = (a_i < b_i) ? a_i : b_i;
      FN_MAX:      res_o = (a_i > b_i) ? a_i : b_i;
      FN_INC:      res_o = sat64(a64 + 64'sd1);
      FN_DEC:      res_o = sat64(a64 - 64'sd1);
      FN_TO_INT:   res_o = a_i >>> FRAC_BITS;
      FN_FROM_INT: res_o = sat64(sh);
      default:     res_o = '0;
    endcase
  end
endmodule

>>> rtl/fxalu_pipe.sv
// Pipelined multiply and restoring-division datapath, one quotient bit per stage
module fxalu_pipe
  import fxalu_pkg::*;
#(
  parameter int FRAC_BITS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic               in_valid_i,
  input  fxa_side_t          in_side_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  output logic               out_valid_o,
  output logic signed [31:0] res_o,
  output logic               cmp_o,
  output logic               dz_o
);
  // Quotient bits: numerator |a|<<FRAC_BITS fits in NW bits, plus one extra
  // bit for the rounding half step (2n+d)/(2d).
  localparam int NW = 32 + FRAC_BITS;
  localparam int QB = NW + 1;

  // Stage 0 registers
  logic               v0_q;
  fxa_side_t          s0_q;
  logic               neg0_q;
  logic [QB-1:0]      num0_q;    // n + d, with n = |a|<<F and d = |b|
  logic [32:0]        den0_q;    // |b|, doubled divisor handled in step
  logic signed [63:0] prod0_q;

  logic [31:0] mag_a, mag_b;
  assign mag_a = a_i[31] ? 32'(-a_i) : 32'(a_i);
  assign mag_b = b_i[31] ? 32'(-b_i) : 32'(b_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (adv_i) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s0_q    <= in_side_i;
      neg0_q  <= a_i[31] ^ b_i[31];
      num0_q  <= {1'b0, mag_a, {FRAC_BITS{1'b0}}} + QB'(mag_b);
      den0_q  <= {1'b0, mag_b};
      prod0_q <= 64'(a_i) * 64'(b_i);
    end
  end
  // Rounded quotient q = floor((2n+d)/(2d)). Dividend D = 2n+d, divisor 2d.

  // Dividend D = 2n + d, QB+1 bits; divide by 2d via restoring steps.
  localparam int DW = QB + 1;
  logic [DW-1:0] dvd0;
  assign dvd0 = {num0_q - QB'(den0_q), 1'b0} + DW'(den0_q);

  logic [DW-1:0] rem_q [QB+1];
  logic [DW-1:0] quo_q [QB+1];
  logic [33:0]   dv_q  [QB+1];
  logic          vv_q  [QB+1];
  fxa_side_t     ss_q  [QB+1];
  logic          ng_q  [QB+1];
  logic signed [63:0] pp_q [QB+1];

  assign rem_q[0] = '0;
  assign quo_q[0] = dvd0;
  assign dv_q[0]  = {den0_q, 1'b0};
  assign vv_q[0]  = v0_q;
  assign ss_q[0]  = s0_q;
  assign ng_q[0]  = neg0_q;
  assign pp_q[0]  = prod0_q;

  for (genvar k = 0; k < QB; k++) begin : g_div
    logic [DW:0]   trial;
    logic [DW-1:0] shr;
    logic          fit;
    logic [DW-1:0] rem_n_q, quo_n_q;
    logic [33:0]   dv_n_q;
    logic          v_n_q;
    fxa_side_t     s_n_q;
    logic          ng_n_q;
    logic signed [63:0] pp_n_q;

    assign shr   = {rem_q[k][DW-2:0], quo_q[k][DW-1]};
    assign trial = {1'b0, shr} - (DW+1)'(dv_q[k]);
    assign fit   = !trial[DW];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_n_q <= 1'b0;
      end else if (adv_i) begin
        v_n_q <= vv_q[k];
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_n_q <= fit ? trial[DW-1:0] : shr;
        quo_n_q <= {quo_q[k][DW-2:0], fit};
        dv_n_q  <= dv_q[k];
        s_n_q   <= ss_q[k];
        ng_n_q  <= ng_q[k];
        pp_n_q  <= pp_q[k];
      end
    end
    assign rem_q[k+1] = rem_n_q;
    assign quo_q[k+1] = quo_n_q;
    assign dv_q[k+1]  = dv_n_q;
    assign vv_q[k+1]  = v_n_q;
    assign ss_q[k+1]  = s_n_q;
    assign ng_q[k+1]  = ng_n_q;
    assign pp_q[k+1]  = pp_n_q;
  end

  // The dividend has DW bits but the top bit is always clear, so QB steps on
  // the upper part leave the last step's bit; run one more plain step.
  logic [DW:0]   tl;
  logic [DW-1:0] shl;
  logic [DW-1:0] qfin;
  assign shl  = {rem_q[QB][DW-2:0], quo_q[QB][DW-1]};
  assign tl   = {1'b0, shl} - (DW+1)'(dv_q[QB]);
  assign qfin = {quo_q[QB][DW-2:0], !tl[DW]};

  // Final stage: signs, rounding of the product, saturation
  logic [63:0]        pmag;
  logic [63:0]        pr;
  logic signed [63:0] mul_s, div_s;
  logic signed [31:0] res_d;
  logic               dz_d;
  always_comb begin
    pmag  = pp_q[QB][63] ? 64'(-pp_q[QB]) : 64'(pp_q[QB]);
    pr    = (pmag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    mul_s = pp_q[QB][63] ? -$signed(pr) : $signed(pr);
    div_s = ng_q[QB] ? -$signed(64'(qfin)) : $signed(64'(qfin));
    dz_d  = 1'b0;
    case (ss_q[QB].func)
      FN_MUL: res_d = sat64(mul_s);
      FN_DIV: begin
        dz_d  = (dv_q[QB] == '0);
        res_d = dz_d ? 32'sd0 : sat64(div_s);
      end
      default: res_d = ss_q[QB].simple_res;
    endcase
  end

  logic v_out_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_out_q <= 1'b0;
    end else if (adv_i) begin
      v_out_q <= vv_q[QB];
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      res_o <= res_d;
      cmp_o <= ss_q[QB].cmp;
      dz_o  <= dz_d;
    end
  end
  assign out_valid_o = v_out_q;
endmodule

>>> rtl/fxalu_checker.sv
// Port-level checker for the fixed-point ALU, bound to the top level
`include "fixed_point_alu_q24_8_unit_defines.svh"
module fxalu_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [31:0] result_raw_o,
  input logic               compare_true_o,
  input logic               divide_by_zero_o
);
  `FXA_ASSERT_CLK(a_flags_excl, clk_i, rst_ni, out_valid_o |-> !(compare_true_o && divide_by_zero_o), "compare and divide flags both set")
  `FXA_ASSERT_CLK(a_dz_zero, clk_i, rst_ni, (out_valid_o && divide_by_zero_o) |-> (result_raw_o == 0), "divide by zero with nonzero result")
  `FXA_ASSERT_CLK(a_stall_path, clk_i, rst_ni, in_stall_o == (out_valid_o && out_stall_i), "input stall not tied to output stall")
  `FXA_ASSERT_CLK(a_hold, clk_i, rst_ni, (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(result_raw_o)), "stalled result changed")
endmodule

bind fixed_point_alu_q24_8_unit fxalu_checker u_fxalu_checker (.*);
